// ----- hw/rtl/lrast_pkg.sv -----
// Shared types and constants for the line rasterizer.
`timescale 1ns / 1ps

package lrast_pkg;

  // Default coordinate width
  localparam int unsigned CoordBitsDef = 10;

  // Pixel color width and its value after reset
  localparam int unsigned ColorW = 32;
  localparam logic [ColorW-1:0] ColorReset = 32'hFFFF_FFFF;

  // Request kinds carried on the input tuser bit
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // latch new endpoints
    logic step;  // emit current pixel and advance
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last;  // current pixel is the final one of the line
  } status_t;

endpackage

// ----- hw/rtl/lrast_ctrl.sv -----
// Controller for the line rasterizer: line state, handshakes and commands.
`timescale 1ns / 1ps

module lrast_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_req_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  lrast_pkg::status_t status_i,
  output lrast_pkg::cmd_t    cmd_o
);
  import lrast_pkg::*;

  typedef enum logic [1:0] {
    ST_EMPTY  = 2'b01,
    ST_ACTIVE = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // Take a beat whenever the output register is free or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Issue commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.load = accept && (in_req_i == REQ_LOAD);
    cmd_o.step = accept && (in_req_i == REQ_STEP) && (state_q == ST_ACTIVE);
  end

  // Track whether a line is loaded
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_EMPTY: begin
        if (cmd_o.load) state_d = ST_ACTIVE;
      end
      ST_ACTIVE: begin
        if (cmd_o.load) state_d = ST_ACTIVE;
        else if (cmd_o.step && status_i.last) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  // Hold the result beat until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.step) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EMPTY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/lrast_dp.sv -----
// Datapath for the line rasterizer: endpoint setup, remainder stepping, output register.
`timescale 1ns / 1ps

module lrast_dp #(
  parameter int unsigned COORD_BITS = lrast_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lrast_pkg::cmd_t              cmd_i,
  output lrast_pkg::status_t           status_o,
  input  logic [COORD_BITS-1:0]        start_x_i,
  input  logic [COORD_BITS-1:0]        start_y_i,
  input  logic [COORD_BITS-1:0]        end_x_i,
  input  logic [COORD_BITS-1:0]        end_y_i,
  input  logic                         cfg_wr_en_i,
  input  logic [lrast_pkg::ColorW-1:0] cfg_wr_data_i,
  output logic [COORD_BITS-1:0]        pixel_x_o,
  output logic [COORD_BITS-1:0]        pixel_y_o,
  output logic [lrast_pkg::ColorW-1:0] color_o,
  output logic                         last_pixel_o
);
  import lrast_pkg::*;

  localparam int unsigned CB = COORD_BITS;

  // Line state
  logic                 steep_q;
  logic [CB-1:0]        maj_end_q;
  logic [CB-1:0]        dx_q;
  logic signed [CB:0]   dy_q;
  logic [CB-1:0]        maj_pos_q, maj_pos_d;
  logic [CB-1:0]        min_pos_q, min_pos_d;
  logic [CB-1:0]        rem_q, rem_d;
  logic [ColorW-1:0]    color_q;

  // Output register
  logic [CB-1:0]        pix_x_q, pix_y_q;
  logic [ColorW-1:0]    pix_color_q;
  logic                 pix_last_q;

  // Setup terms
  logic [CB-1:0]        ddx, ddy;
  logic                 steep_w, swap_w;
  logic [CB-1:0]        ma, mb, na, nb;
  logic [CB-1:0]        maj_s, maj_e, min_s, min_e;
  logic [CB-1:0]        dx_w;
  logic signed [CB:0]   dy_w;

  // Stepping terms
  logic signed [CB+1:0] sum, sum_adj;
  logic                 last_w;

  // Classify and order the endpoints
  always_comb begin
    ddx     = (start_x_i > end_x_i) ? (start_x_i - end_x_i) : (end_x_i - start_x_i);
    ddy     = (start_y_i > end_y_i) ? (start_y_i - end_y_i) : (end_y_i - start_y_i);
    steep_w = ddx < ddy;
    ma      = steep_w ? start_y_i : start_x_i;
    mb      = steep_w ? end_y_i   : end_x_i;
    na      = steep_w ? start_x_i : start_y_i;
    nb      = steep_w ? end_x_i   : end_y_i;
    swap_w  = ma > mb;
    maj_s   = swap_w ? mb : ma;
    maj_e   = swap_w ? ma : mb;
    min_s   = swap_w ? nb : na;
    min_e   = swap_w ? na : nb;
    dx_w    = maj_e - maj_s;
    dy_w    = $signed({1'b0, min_e}) - $signed({1'b0, min_s});
  end

  assign last_w          = maj_pos_q >= maj_end_q;
  assign status_o.last   = last_w;

  // Advance the running remainder by one major step
  always_comb begin
    sum       = $signed({2'b00, rem_q}) + $signed({dy_q[CB], dy_q});
    sum_adj   = sum;
    min_pos_d = min_pos_q;
    if (!dy_q[CB]) begin
      if (sum >= $signed({2'b00, dx_q})) begin
        sum_adj   = sum - $signed({2'b00, dx_q});
        min_pos_d = min_pos_q + 1'b1;
      end
    end else begin
      if (sum < 0) begin
        sum_adj   = sum + $signed({2'b00, dx_q});
        min_pos_d = min_pos_q - 1'b1;
      end
    end
    rem_d     = sum_adj[CB-1:0];
    maj_pos_d = maj_pos_q + 1'b1;
  end

  // Load a line or step it
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      steep_q   <= steep_w;
      maj_end_q <= maj_e;
      dx_q      <= dx_w;
      dy_q      <= dy_w;
      maj_pos_q <= maj_s;
      min_pos_q <= min_s;
      rem_q     <= '0;
    end else if (cmd_i.step && !last_w) begin
      maj_pos_q <= maj_pos_d;
      min_pos_q <= min_pos_d;
      rem_q     <= rem_d;
    end
  end

  // Capture the pixel beat, swapped back for steep lines
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pix_x_q     <= steep_q ? min_pos_q : maj_pos_q;
      pix_y_q     <= steep_q ? maj_pos_q : min_pos_q;
      pix_color_q <= color_q;
      pix_last_q  <= last_w;
    end
  end

  // Color register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= ColorReset;
    end else if (cfg_wr_en_i) begin
      color_q <= cfg_wr_data_i;
    end
  end

  assign pixel_x_o    = pix_x_q;
  assign pixel_y_o    = pix_y_q;
  assign color_o      = pix_color_q;
  assign last_pixel_o = pix_last_q;

endmodule

// ----- hw/rtl/line_rasterizer.sv -----
// Top level of the line rasterizer: stream ports, controller and datapath.
//
// A load beat (tuser 0) latches two endpoints and returns nothing; each step beat
// (tuser 1) returns one pixel beat with the configured color, tlast set on the final
// pixel of the line. Steps with no line loaded, or after the final pixel, return
// nothing. A new load replaces any line in progress. The block takes one beat per
// cycle: a step is resolved in the cycle it is accepted by a running remainder
// (one add and compare), and its pixel lands in a one-deep output register. While
// that register holds a beat the downstream side has not taken, s_axis_tready is low.
// The color register may be written at any time; it applies to later steps.
`timescale 1ns / 1ps

module line_rasterizer #(
  parameter int unsigned COORD_BITS = lrast_pkg::CoordBitsDef,
  localparam int unsigned IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * COORD_BITS + lrast_pkg::ColorW + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [IN_W-1:0]              s_axis_tdata,  // start_x, start_y, end_x, end_y
  input  logic                         s_axis_tuser,  // req_type
  // Output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [OUT_W-1:0]             m_axis_tdata,  // pixel_x, pixel_y, color, zero pad
  output logic                         m_axis_tlast,  // last_pixel
  // Configuration
  input  logic                         cfg_wr_en_i,
  input  logic [lrast_pkg::ColorW-1:0] cfg_wr_data_i
);
  import lrast_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned PAY_W = 2 * CB + ColorW;

  cmd_t              cmd;
  status_t           status;
  logic [CB-1:0]     pixel_x, pixel_y;
  logic [ColorW-1:0] color;

  lrast_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_req_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lrast_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .start_x_i     (s_axis_tdata[CB-1:0]),
    .start_y_i     (s_axis_tdata[2*CB-1:CB]),
    .end_x_i       (s_axis_tdata[3*CB-1:2*CB]),
    .end_y_i       (s_axis_tdata[4*CB-1:3*CB]),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .color_o       (color),
    .last_pixel_o  (m_axis_tlast)
  );

  // Pack the pixel beat, zero filled to whole bytes
  always_comb begin
    m_axis_tdata            = '0;
    m_axis_tdata[PAY_W-1:0] = {color, pixel_y, pixel_x};
  end

endmodule
